// File: hw/rtl/otb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// otb_pkg
// shared types and constants of the overwriting trace buffer
// ----------------------------------------------------------------------------
package otb_pkg;

  localparam int unsigned OP_BITS      = 2;
  localparam int unsigned TURN_BITS    = 16;
  localparam int unsigned PAYLOAD_BITS = 48;
  localparam int unsigned COUNT_BITS   = 7;

  typedef enum logic [OP_BITS-1:0] {
    OP_APPEND      = 2'd0,
    OP_READ_NEWEST = 2'd1,
    OP_READ_TURN   = 2'd2,
    OP_CLEAR       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_FLUSH
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/otb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// otb channel interfaces
// command word and response word channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface otb_cmd_if;
  logic                                        valid;
  logic                                        ready;
  otb_pkg::op_t                                opcode;
  logic signed [otb_pkg::TURN_BITS-1:0]        turn_number;
  logic        [otb_pkg::PAYLOAD_BITS-1:0]     event_payload;
  logic        [otb_pkg::COUNT_BITS-1:0]       request_count;

  modport source (
    output valid, opcode, turn_number, event_payload, request_count,
    input  ready
  );
  modport sink (
    input  valid, opcode, turn_number, event_payload, request_count,
    output ready
  );
endinterface

interface otb_rsp_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [otb_pkg::TURN_BITS-1:0]        out_turn;
  logic        [otb_pkg::PAYLOAD_BITS-1:0]     out_payload;
  logic                                        record_valid;
  logic                                        last_of_run;
  logic        [otb_pkg::COUNT_BITS-1:0]       entries_held;

  modport source (
    output valid, out_turn, out_payload, record_valid, last_of_run, entries_held,
    input  ready
  );
  modport sink (
    input  valid, out_turn, out_payload, record_valid, last_of_run, entries_held,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/overwriting_trace_buffer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// overwriting_trace_buffer_core
// ring store of tagged records, oldest overwritten when full, with
// newest-n readout, per-turn filtered readout and clear
// ----------------------------------------------------------------------------
// append and clear: ack word the cycle after accept, one command per cycle
//   while responses are taken; reads: memory read, then check, per record,
//   then a closing word; newest-n scans min(n, fill), per-turn the whole fill
// commands are held off while a read walks the store
// reset clears write pointer and fill level; store contents are not cleared
// ----------------------------------------------------------------------------
module overwriting_trace_buffer_core #(
  parameter int unsigned DEPTH         = 64,
  parameter int unsigned TURN_WIDTH    = 16,
  parameter int unsigned PAYLOAD_WIDTH = 48
) (
  input  wire logic clk,
  input  wire logic rst,
  otb_cmd_if.sink   cmd,
  otb_rsp_if.source rsp
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned MW   = TURN_WIDTH + PAYLOAD_WIDTH;
  localparam int unsigned EXTW = (TURN_WIDTH > otb_pkg::TURN_BITS) ?
                                 TURN_WIDTH : otb_pkg::TURN_BITS;

  // store
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rd_q;

  // control state
  otb_pkg::state_t state, state_next;
  logic [AW-1:0]   wp;
  logic [CW-1:0]   fill;
  logic [AW-1:0]   addr;
  logic [CW-1:0]   rem;
  logic            filter;
  logic [TURN_WIDTH-1:0] key;
  logic            pend_v;
  logic [MW-1:0]   pend;

  // output register
  logic                                   out_valid;
  logic signed [otb_pkg::TURN_BITS-1:0]   out_turn;
  logic [otb_pkg::PAYLOAD_BITS-1:0]       out_payload;
  logic                                   out_rec_valid;
  logic                                   out_last;
  logic [otb_pkg::COUNT_BITS-1:0]         out_held;

  // combinational
  logic            accept;
  logic            out_free;
  logic            is_read;
  logic [CW-1:0]   fill_next;
  logic [AW-1:0]   wp_inc;
  logic [AW-1:0]   addr_inc;
  logic [otb_pkg::COUNT_BITS-1:0] req_clip;
  logic [CW-1:0]   cnt;
  logic [CW:0]     start_w;
  logic [AW-1:0]   start;
  logic [EXTW-1:0] turn_in_ext;
  logic [TURN_WIDTH-1:0] turn_in;
  logic            sel;
  logic            emit_pend;
  logic            check_go;
  logic            mem_we;
  logic            rd_en;
  logic            out_load;
  logic [MW-1:0]   load_rec;
  logic            load_rec_valid;
  logic            load_last;
  logic [CW-1:0]   load_held;
  logic signed [TURN_WIDTH-1:0] load_tag;
  logic [EXTW-1:0] load_tag_ext;

  assign out_free = !out_valid || rsp.ready;
  assign accept   = cmd.valid && cmd.ready;
  assign is_read  = (cmd.opcode == otb_pkg::OP_READ_NEWEST) ||
                    (cmd.opcode == otb_pkg::OP_READ_TURN);

  assign wp_inc   = (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
  assign addr_inc = (addr == AW'(DEPTH - 1)) ? '0 : addr + 1'b1;

  assign turn_in_ext = EXTW'(cmd.turn_number);
  assign turn_in     = turn_in_ext[TURN_WIDTH-1:0];

  // count to scan and oldest slot of the run
  always_comb begin
    req_clip = (cmd.request_count < otb_pkg::COUNT_BITS'(fill)) ?
               cmd.request_count : otb_pkg::COUNT_BITS'(fill);
    cnt = (cmd.opcode == otb_pkg::OP_READ_NEWEST) ? CW'(req_clip) : fill;
    if ((CW + 1)'(wp) >= (CW + 1)'(cnt)) begin
      start_w = (CW + 1)'(wp) - (CW + 1)'(cnt);
    end else begin
      start_w = (CW + 1)'(wp) + (CW + 1)'(DEPTH) - (CW + 1)'(cnt);
    end
    start = start_w[AW-1:0];
  end

  assign sel       = !filter || (rd_q[MW-1 -: TURN_WIDTH] == key);
  assign emit_pend = sel && pend_v;
  assign check_go  = !emit_pend || out_free;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      otb_pkg::ST_IDLE: begin
        if (accept && is_read) begin
          state_next = (cnt == '0) ? otb_pkg::ST_FLUSH : otb_pkg::ST_FETCH;
        end
      end
      otb_pkg::ST_FETCH: begin
        state_next = otb_pkg::ST_CHECK;
      end
      otb_pkg::ST_CHECK: begin
        if (check_go) begin
          state_next = (rem == '0) ? otb_pkg::ST_FLUSH : otb_pkg::ST_FETCH;
        end
      end
      otb_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_next = otb_pkg::ST_IDLE;
        end
      end
      default: state_next = otb_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    cmd.ready      = 1'b0;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    out_load       = 1'b0;
    load_rec       = '0;
    load_rec_valid = 1'b0;
    load_last      = 1'b1;
    load_held      = fill;
    fill_next      = fill;
    unique case (state)
      otb_pkg::ST_IDLE: begin
        cmd.ready = out_free;
        if (cmd.valid && out_free) begin
          unique case (cmd.opcode)
            otb_pkg::OP_APPEND: begin
              mem_we    = 1'b1;
              fill_next = (fill == CW'(DEPTH)) ? fill : fill + 1'b1;
              out_load  = 1'b1;
            end
            otb_pkg::OP_CLEAR: begin
              fill_next = '0;
              out_load  = 1'b1;
            end
            otb_pkg::OP_READ_NEWEST,
            otb_pkg::OP_READ_TURN: begin
              out_load = 1'b0;
            end
            default: out_load = 1'b0;
          endcase
          load_held = fill_next;
        end
      end
      otb_pkg::ST_FETCH: begin
        rd_en = 1'b1;
      end
      otb_pkg::ST_CHECK: begin
        if (emit_pend && out_free) begin
          out_load       = 1'b1;
          load_rec       = pend;
          load_rec_valid = 1'b1;
          load_last      = 1'b0;
        end
      end
      otb_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_load       = 1'b1;
          load_rec       = pend_v ? pend : '0;
          load_rec_valid = pend_v;
        end
      end
      default: cmd.ready = 1'b0;
    endcase
  end

  assign load_tag     = load_rec[MW-1 -: TURN_WIDTH];
  assign load_tag_ext = EXTW'(load_tag);

  // memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= {turn_in, cmd.event_payload[PAYLOAD_WIDTH-1:0]};
    end
    if (rd_en) begin
      rd_q <= mem[addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= otb_pkg::ST_IDLE;
      wp        <= '0;
      fill      <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (accept && cmd.opcode == otb_pkg::OP_APPEND) begin
        wp <= wp_inc;
      end else if (accept && cmd.opcode == otb_pkg::OP_CLEAR) begin
        wp <= '0;
      end
      if (accept && is_read) begin
        pend_v <= 1'b0;
      end else if (state == otb_pkg::ST_CHECK && check_go && sel) begin
        pend_v <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk and payload registers
  always_ff @(posedge clk) begin
    if (accept && is_read) begin
      addr   <= start;
      rem    <= cnt;
      filter <= (cmd.opcode == otb_pkg::OP_READ_TURN);
      key    <= turn_in;
    end else if (state == otb_pkg::ST_FETCH) begin
      addr <= addr_inc;
      rem  <= rem - 1'b1;
    end
    if (state == otb_pkg::ST_CHECK && check_go && sel) begin
      pend <= rd_q;
    end
    if (out_load) begin
      out_turn      <= load_tag_ext[otb_pkg::TURN_BITS-1:0];
      out_payload   <= otb_pkg::PAYLOAD_BITS'(load_rec[PAYLOAD_WIDTH-1:0]);
      out_rec_valid <= load_rec_valid;
      out_last      <= load_last;
      out_held      <= otb_pkg::COUNT_BITS'(load_held);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.out_turn     = out_turn;
  assign rsp.out_payload  = out_payload;
  assign rsp.record_valid = out_rec_valid;
  assign rsp.last_of_run  = out_last;
  assign rsp.entries_held = out_held;

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> state == otb_pkg::ST_IDLE)
    else $error("command taken while a read walks the store");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill level above depth");

  a_append_fill: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == otb_pkg::OP_APPEND |=>
      (fill == (($past(fill) == CW'(DEPTH)) ? $past(fill) : $past(fill) + 1'b1)))
    else $error("append did not advance fill level");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    state == otb_pkg::ST_FLUSH && out_free |=> out_valid && out_last)
    else $error("read run closed without a last word");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rec_valid |-> out_last)
    else $error("word without record not marked last");

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// overwriting trace buffer testbench
// drives append, newest-n read, per-turn read and clear commands with random
// gaps on the command side and random stalls on the response side; a local
// model of the ring store predicts every response word, and each accepted
// word is checked field by field against the oldest prediction
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH       = 64;
  localparam int DRAIN_WAIT  = 160;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 230;

  typedef logic signed [otb_pkg::TURN_BITS-1:0] turn_t;
  typedef logic [otb_pkg::PAYLOAD_BITS-1:0]     payload_t;
  typedef logic [otb_pkg::COUNT_BITS-1:0]       count_t;

  typedef struct {
    turn_t    turn;
    payload_t payload;
    logic     rec_valid;
    logic     last;
    count_t   held;
  } rsp_word_t;

  logic clk;
  logic rst;

  otb_cmd_if cmd_if ();
  otb_rsp_if rsp_if ();

  overwriting_trace_buffer_core DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  // ring store model
  turn_t     trace_turn [DEPTH];
  payload_t  trace_payload [DEPTH];
  int        wr_slot;
  int        held_count;

  rsp_word_t expected_words [$];
  rsp_word_t exp_word;
  int        error_count;
  int        items_sent;
  int        cycle_count;
  bit        cmd_idle_en;
  bit        rsp_stall_en;
  int        rsp_hold;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap(bit en);
    int r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic payload_t rand_payload();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[otb_pkg::PAYLOAD_BITS-1:0];
  endfunction

  function automatic void push_word(turn_t t, payload_t p, logic v, logic l);
    rsp_word_t w;
    w.turn      = t;
    w.payload   = p;
    w.rec_valid = v;
    w.last      = l;
    w.held      = count_t'(held_count);
    expected_words = {expected_words, w};
  endfunction

  function automatic void predict_trace(otb_pkg::op_t op, turn_t turn, payload_t pay,
                                        count_t cnt);
    int n;
    int start;
    int idx;
    int match_count;
    int k;
    case (op)
      otb_pkg::OP_APPEND: begin
        trace_turn[wr_slot]    = turn;
        trace_payload[wr_slot] = pay;
        wr_slot = (wr_slot + 1) % DEPTH;
        if (held_count < DEPTH) held_count++;
        push_word('0, '0, 1'b0, 1'b1);
      end
      otb_pkg::OP_CLEAR: begin
        wr_slot    = 0;
        held_count = 0;
        push_word('0, '0, 1'b0, 1'b1);
      end
      otb_pkg::OP_READ_NEWEST: begin
        n = (int'(cnt) < held_count) ? int'(cnt) : held_count;
        start = (wr_slot + DEPTH - n) % DEPTH;
        for (int i = 0; i < n; i++) begin
          idx = (start + i) % DEPTH;
          push_word(trace_turn[idx], trace_payload[idx], 1'b1, i == n - 1);
        end
        if (n == 0) push_word('0, '0, 1'b0, 1'b1);
      end
      default: begin
        start = (wr_slot + DEPTH - held_count) % DEPTH;
        match_count = 0;
        for (int i = 0; i < held_count; i++)
          if (trace_turn[(start + i) % DEPTH] == turn) match_count++;
        k = 0;
        for (int i = 0; i < held_count; i++) begin
          idx = (start + i) % DEPTH;
          if (trace_turn[idx] == turn) begin
            push_word(trace_turn[idx], trace_payload[idx], 1'b1, k == match_count - 1);
            k++;
          end
        end
        if (match_count == 0) push_word('0, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_cmd(otb_pkg::op_t op, turn_t turn, payload_t pay, count_t cnt);
    int gap;
    gap = pick_gap(cmd_idle_en);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.opcode        <= op;
    cmd_if.turn_number   <= turn;
    cmd_if.event_payload <= pay;
    cmd_if.request_count <= cnt;
    do @(posedge clk); while (!cmd_if.ready);
    predict_trace(op, turn, pay, cnt);
    items_sent++;
    @(negedge clk);
  endtask

  // response side ready with random stalls
  always @(negedge clk) begin
    if (rsp_hold == 0) begin
      if (!rsp_stall_en || $urandom_range(0, 2) != 0) begin
        rsp_if.ready <= 1'b1;
        rsp_hold     <= $urandom_range(1, 8);
      end else begin
        rsp_if.ready <= 1'b0;
        rsp_hold     <= pick_gap(1'b1) + 1;
      end
    end else begin
      rsp_hold <= rsp_hold - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: response word with none expected, turn %0d payload %h", $time,
                 rsp_if.out_turn, rsp_if.out_payload);
        error_count++;
      end else begin
        exp_word = expected_words.pop_front();
        if (rsp_if.out_turn !== exp_word.turn) begin
          $display("%0t: out_turn expected %0d actual %0d", $time, exp_word.turn,
                   rsp_if.out_turn);
          error_count++;
        end
        if (rsp_if.out_payload !== exp_word.payload) begin
          $display("%0t: out_payload expected %h actual %h", $time, exp_word.payload,
                   rsp_if.out_payload);
          error_count++;
        end
        if (rsp_if.record_valid !== exp_word.rec_valid) begin
          $display("%0t: record_valid expected %b actual %b", $time, exp_word.rec_valid,
                   rsp_if.record_valid);
          error_count++;
        end
        if (rsp_if.last_of_run !== exp_word.last) begin
          $display("%0t: last_of_run expected %b actual %b", $time, exp_word.last,
                   rsp_if.last_of_run);
          error_count++;
        end
        if (rsp_if.entries_held !== exp_word.held) begin
          $display("%0t: entries_held expected %0d actual %0d", $time, exp_word.held,
                   rsp_if.entries_held);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_empty_reads();
    send_cmd(otb_pkg::OP_READ_NEWEST, 16'sd0, '0, 7'd64);
    send_cmd(otb_pkg::OP_READ_TURN, 16'sd0, '1, 7'd0);
  endtask

  task automatic test_append_extremes();
    send_cmd(otb_pkg::OP_APPEND, -16'sd32768, '0, 7'd0);
    send_cmd(otb_pkg::OP_APPEND, 16'sd32767, '1, 7'd64);
    send_cmd(otb_pkg::OP_APPEND, -16'sd1, 48'hAAAA_AAAA_AAAA, 7'd42);
    send_cmd(otb_pkg::OP_APPEND, 16'sd0, 48'h5555_5555_5555, 7'd21);
    send_cmd(otb_pkg::OP_APPEND, 16'sd32767, rand_payload(), 7'd1);
  endtask

  task automatic test_count_clipping();
    send_cmd(otb_pkg::OP_READ_NEWEST, 16'sd5, rand_payload(), 7'd0);
    send_cmd(otb_pkg::OP_READ_NEWEST, -16'sd5, rand_payload(), 7'd3);
    send_cmd(otb_pkg::OP_READ_NEWEST, 16'sd0, rand_payload(), 7'd64);
  endtask

  task automatic test_turn_filter();
    send_cmd(otb_pkg::OP_READ_TURN, 16'sd32767, rand_payload(), 7'd63);
    send_cmd(otb_pkg::OP_READ_TURN, -16'sd32768, rand_payload(), 7'd0);
    send_cmd(otb_pkg::OP_READ_TURN, 16'sd1234, rand_payload(), 7'd7);
  endtask

  task automatic test_clear();
    send_cmd(otb_pkg::OP_CLEAR, 16'sd99, '1, 7'd64);
    send_cmd(otb_pkg::OP_READ_NEWEST, 16'sd0, '0, 7'd64);
    send_cmd(otb_pkg::OP_READ_TURN, -16'sd1, '0, 7'd0);
    send_cmd(otb_pkg::OP_APPEND, 16'sd5, rand_payload(), 7'd0);
    send_cmd(otb_pkg::OP_READ_NEWEST, 16'sd0, '0, 7'd1);
    send_cmd(otb_pkg::OP_CLEAR, -16'sd1, '0, 7'd0);
  endtask

  // fill past the depth so the oldest records are overwritten
  task automatic test_wraparound();
    turn_t tags [4];
    foreach (tags[i]) tags[i] = turn_t'($urandom);
    for (int i = 0; i < 70; i++)
      send_cmd(otb_pkg::OP_APPEND, tags[$urandom_range(0, 3)], rand_payload(),
               count_t'($urandom_range(0, 64)));
    send_cmd(otb_pkg::OP_READ_NEWEST, turn_t'($urandom), rand_payload(), 7'd64);
    send_cmd(otb_pkg::OP_READ_NEWEST, turn_t'($urandom), rand_payload(), 7'd63);
    send_cmd(otb_pkg::OP_READ_TURN, tags[0], rand_payload(),
             count_t'($urandom_range(0, 64)));
  endtask

  task automatic test_random_traffic(int first_item);
    turn_t tags [4];
    int    burst;
    int    reads;
    while (items_sent < first_item + RANDOM_ITEMS) begin
      cmd_idle_en  = $urandom_range(0, 3) != 0;
      rsp_stall_en = $urandom_range(0, 3) != 0;
      foreach (tags[i]) tags[i] = turn_t'($urandom);
      if ($urandom_range(0, 9) == 0)
        send_cmd(otb_pkg::OP_CLEAR, turn_t'($urandom), rand_payload(),
                 count_t'($urandom_range(0, 64)));
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
      for (int i = 0; i < burst && items_sent < first_item + RANDOM_ITEMS; i++)
        send_cmd(otb_pkg::OP_APPEND, tags[$urandom_range(0, 3)], rand_payload(),
                 count_t'($urandom_range(0, 64)));
      reads = $urandom_range(1, 3);
      for (int i = 0; i < reads; i++) begin
        case ($urandom_range(0, 5))
          0, 1: send_cmd(otb_pkg::OP_READ_NEWEST, turn_t'($urandom), rand_payload(),
                         count_t'($urandom_range(0, 64)));
          2, 3: send_cmd(otb_pkg::OP_READ_TURN, tags[$urandom_range(0, 3)], rand_payload(),
                         count_t'($urandom_range(0, 64)));
          4: send_cmd(otb_pkg::OP_READ_TURN, turn_t'($urandom), rand_payload(),
                      count_t'($urandom_range(0, 64)));
          default: send_cmd(otb_pkg::op_t'($urandom_range(0, 3)), turn_t'($urandom),
                            rand_payload(), count_t'($urandom_range(0, 64)));
        endcase
      end
    end
  endtask

  initial begin
    rst                  = 1'b1;
    cmd_if.valid         = 1'b0;
    cmd_if.opcode        = otb_pkg::OP_APPEND;
    cmd_if.turn_number   = '0;
    cmd_if.event_payload = '0;
    cmd_if.request_count = '0;
    rsp_if.ready         = 1'b0;
    rsp_hold             = 0;
    wr_slot              = 0;
    held_count           = 0;
    error_count          = 0;
    items_sent           = 0;
    cycle_count          = 0;
    cmd_idle_en          = 1'b1;
    rsp_stall_en         = 1'b1;
    foreach (trace_turn[i]) begin
      trace_turn[i]    = '0;
      trace_payload[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_reads();
    test_append_extremes();
    test_count_clipping();
    test_turn_filter();
    test_clear();
    test_wraparound();
    test_random_traffic(0);

    cmd_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
